### design/stfp_pkg.sv
// ----------------------------------------------------------------------------
// Frame parser package
// Constants, types and the function-code lookup that the frame parser uses.
// ----------------------------------------------------------------------------
package stfp_pkg;

  localparam int MAX_PAYLOAD_BYTES = 6;
  localparam int FRAME_PAYLOAD_W   = 48;
  localparam int PACK_BYTES        = FRAME_PAYLOAD_W / 8;

  localparam logic [7:0] SYNC_BYTE    = 8'hFB;
  localparam logic [7:0] FUNC_LEN_SIX = 8'h31;
  localparam logic [7:0] FUNC_LEN_TWO = 8'h32;
  localparam logic [7:0] FUNC_LEN_FOUR = 8'h33;
  localparam logic [7:0] FUNC_LEN_ONE = 8'h34;

  localparam logic [2:0] LEN_NONE = 3'd0;

  typedef enum logic [4:0] {
    PH_HUNT = 5'b00001,
    PH_ADDR = 5'b00010,
    PH_FUNC = 5'b00100,
    PH_DATA = 5'b01000,
    PH_SUM  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [7:0]                 address;
    logic [7:0]                 func_code;
    logic [2:0]                 length;
    logic [FRAME_PAYLOAD_W-1:0] payload;
  } frame_t;

  // Payload length selected by a function code; LEN_NONE for an unknown code.
  function automatic logic [2:0] length_for_code(input logic [7:0] code);
    logic [2:0] len;
    unique case (code)
      FUNC_LEN_SIX:  len = 3'd6;
      FUNC_LEN_TWO:  len = 3'd2;
      FUNC_LEN_FOUR: len = 3'd4;
      FUNC_LEN_ONE:  len = 3'd1;
      default:       len = LEN_NONE;
    endcase
    return len;
  endfunction

endpackage

### design/stfp_if.sv
// ----------------------------------------------------------------------------
// Frame parser channel interfaces
// Valid/ready channels for received bytes and for parsed frames.
// ----------------------------------------------------------------------------
interface stfp_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface stfp_frame_if;
  logic        valid;
  logic        ready;
  logic [7:0]  frame_address;
  logic [7:0]  frame_function;
  logic [2:0]  frame_length;
  logic [47:0] frame_payload;

  modport source (output valid, output frame_address, output frame_function,
                  output frame_length, output frame_payload, input ready);
  modport sink   (input valid, input frame_address, input frame_function,
                  input frame_length, input frame_payload, output ready);
endinterface

### design/stfp_in_stage.sv
// ----------------------------------------------------------------------------
// Frame parser input stage
// Registers one received byte; refills in the same cycle the byte moves on.
// ----------------------------------------------------------------------------
module stfp_in_stage (
  input  logic        clk,
  input  logic        rst,
  stfp_rx_if.sink     rx,
  input  logic        advance,
  output logic        byte_valid,
  output logic [7:0]  byte_q
);

  assign rx.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (rx.ready) begin
      byte_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      byte_q <= rx.rx_byte;
    end
  end

endmodule

### design/stfp_parser.sv
// ----------------------------------------------------------------------------
// Frame parser state machine
// Holds the frame state and works out the next state and any finished frame
// for the byte presented in this cycle.
// ----------------------------------------------------------------------------
module stfp_parser (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [7:0]      byte_in,
  output logic            res_valid,
  output stfp_pkg::frame_t res
);
  import stfp_pkg::*;

  phase_t     phase, phase_next;
  logic [7:0] held_address, held_address_next;
  logic [7:0] held_function, held_function_next;
  logic [2:0] payload_len, payload_len_next;
  logic [2:0] bytes_collected, bytes_collected_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] payload_store [MAX_PAYLOAD_BYTES];
  logic       store_we;
  logic       clear_all;
  logic [2:0] code_len;
  logic [7:0] sum_plus;

  assign code_len = length_for_code(byte_in);
  assign sum_plus = running_sum + byte_in;

  always_comb begin
    phase_next           = phase;
    held_address_next    = held_address;
    held_function_next   = held_function;
    payload_len_next     = payload_len;
    bytes_collected_next = bytes_collected;
    running_sum_next     = running_sum;
    store_we             = 1'b0;
    clear_all            = 1'b0;
    res_valid            = 1'b0;
    unique case (phase)
      PH_HUNT: begin
        if (byte_in == SYNC_BYTE) begin
          phase_next       = PH_ADDR;
          running_sum_next = SYNC_BYTE;
        end
      end
      PH_ADDR: begin
        held_address_next = byte_in;
        running_sum_next  = sum_plus;
        phase_next        = PH_FUNC;
      end
      PH_FUNC: begin
        if (code_len == LEN_NONE) begin
          clear_all = 1'b1;
        end else begin
          held_function_next   = byte_in;
          payload_len_next     = code_len;
          bytes_collected_next = 3'd0;
          running_sum_next     = sum_plus;
          phase_next           = PH_DATA;
        end
      end
      PH_DATA: begin
        store_we             = int'(bytes_collected) < MAX_PAYLOAD_BYTES;
        bytes_collected_next = bytes_collected + 3'd1;
        running_sum_next     = sum_plus;
        if (bytes_collected_next >= payload_len) begin
          phase_next = PH_SUM;
        end
      end
      PH_SUM: begin
        res_valid = (byte_in == running_sum);
        clear_all = 1'b1;
      end
      default: begin
        clear_all = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear_all)) begin
      phase           <= PH_HUNT;
      held_address    <= '0;
      held_function   <= '0;
      payload_len     <= '0;
      bytes_collected <= '0;
      running_sum     <= '0;
    end else if (step) begin
      phase           <= phase_next;
      held_address    <= held_address_next;
      held_function   <= held_function_next;
      payload_len     <= payload_len_next;
      bytes_collected <= bytes_collected_next;
      running_sum     <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && clear_all)) begin
      for (int i = 0; i < MAX_PAYLOAD_BYTES; i++) begin
        payload_store[i] <= '0;
      end
    end else if (step && store_we) begin
      payload_store[bytes_collected] <= byte_in;
    end
  end

  // Bytes past the frame length are forced to zero in the packed word.
  always_comb begin
    res.address   = held_address;
    res.func_code = held_function;
    res.length    = payload_len;
    res.payload   = '0;
    for (int i = 0; i < PACK_BYTES && i < MAX_PAYLOAD_BYTES; i++) begin
      if (i < int'(payload_len)) begin
        res.payload[8*i +: 8] = payload_store[i];
      end
    end
  end

  a_result_only_at_checksum: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> phase == PH_SUM)
    else $error("frame result outside the checksum phase");

  a_result_length_legal: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.length == 3'd1 || res.length == 3'd2 ||
                   res.length == 3'd4 || res.length == 3'd6))
    else $error("frame result carries an illegal length");

  a_collect_below_length: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_collected < payload_len)
    else $error("payload count reached the length while still collecting");

  a_hunt_after_result: assert property (@(posedge clk) disable iff (rst)
    step && res_valid |=> phase == PH_HUNT && running_sum == 8'd0)
    else $error("parser did not return to the hunt after a frame");

endmodule

### design/stfp_out_reg.sv
// ----------------------------------------------------------------------------
// Frame parser output register
// Holds one finished frame until the downstream side takes it.
// ----------------------------------------------------------------------------
module stfp_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  stfp_pkg::frame_t res,
  output logic             out_free,
  stfp_frame_if.source     frame
);
  import stfp_pkg::*;

  assign out_free = !frame.valid || frame.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (load) begin
      frame.valid <= 1'b1;
    end else if (frame.ready) begin
      frame.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame.frame_address  <= res.address;
      frame.frame_function <= res.func_code;
      frame.frame_length   <= res.length;
      frame.frame_payload  <= res.payload;
    end
  end

endmodule

### design/servo_telemetry_frame_parser.sv
// ----------------------------------------------------------------------------
// Servo telemetry frame parser
// This block takes received serial bytes one transaction at a time on the rx
// channel, hunts for the sync byte 0xFB, then reads an address byte and a
// function code (0x31, 0x32, 0x33 or 0x34 select 6, 2, 4 or 1 payload bytes;
// any other code drops the frame). After the payload it compares the next
// byte with the 8-bit wrapping sum of all frame bytes from the sync byte
// through the payload, and on a match sends one transaction on the frame
// channel with address, function code, length and the packed payload (first
// byte in bits 7:0, unused bytes zero). A checksum mismatch drops the frame
// silently, and the failing byte is not reconsidered as a sync byte. The
// block takes one byte per clock cycle while the output register is free;
// a byte passes through the input register and the parser logic into the
// output register, which then raises valid on the frame channel. The rate
// is set by the output register: the parser advances in any cycle in which
// that register is empty or being emptied, so the block only slows down
// while the frame sink holds off ready.
// ----------------------------------------------------------------------------
module servo_telemetry_frame_parser (
  input  logic         clk,
  input  logic         rst,
  stfp_rx_if.sink      rx,
  stfp_frame_if.source frame
);
  import stfp_pkg::*;

  logic       byte_valid;
  logic [7:0] byte_q;
  logic       advance;
  logic       out_free;
  logic       res_valid;
  frame_t     res;

  // The registered byte moves through the parser whenever a possible result
  // has a place to go. Bytes that produce no frame advance under the same
  // condition, which keeps the control simple and costs nothing while the
  // sink is ready.
  assign advance = byte_valid && out_free;

  // Input register: parts the upstream handshake from the parser logic.
  stfp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  // Parser: frame state plus the combinational next-state and result logic.
  stfp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .byte_in   (byte_q),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: a finished frame waits here for the frame sink, while
  // further bytes keep coming in as long as it can be refilled.
  stfp_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && res_valid),
    .res      (res),
    .out_free (out_free),
    .frame    (frame)
  );

endmodule

### dv/tb_servo_telemetry_frame_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Servo telemetry frame parser testbench
// Streams received bytes into the parser and checks every parsed frame against
// a cycle-free model of the sync, address, function, payload and checksum
// phases. A short directed sequence covers the field extremes, every function
// code, dropped frames and bytes that must not restart the sync hunt. Random
// traffic follows: mostly well-formed frames, plus bad checksums, unknown
// codes, line noise and truncated frames. It runs under three handshake
// pressure mixes.
// ----------------------------------------------------------------------------
module tb_servo_telemetry_frame_parser;
  import stfp_pkg::*;

  // Function codes and the payload length that each one selects, for building
  // frames on the stimulus side.
  localparam logic [7:0] FUNC_CODES [4] = '{FUNC_LEN_SIX, FUNC_LEN_TWO,
                                           FUNC_LEN_FOUR, FUNC_LEN_ONE};
  localparam logic [2:0] FUNC_LENS  [4] = '{3'd6, 3'd2, 3'd4, 3'd1};

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #4 clk = ~clk;

  stfp_rx_if    rx_ch();
  stfp_frame_if frame_ch();

  servo_telemetry_frame_parser DUT (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_ch),
    .frame (frame_ch)
  );

  // Bytes still waiting to be sent, and frames that the parser owes us, in
  // the order in which they must come out.
  logic [7:0] tx_bytes[$];
  frame_t     predicted_frames[$];

  // Chance in percent that the byte sender or the frame sink holds off in a
  // given cycle. The stimulus process changes these between phases.
  int send_idle_pct = 22;
  int recv_idle_pct = 83;
  int mismatches    = 0;

  // Parser model state. It advances once per accepted rx transaction.
  phase_t     parse_state = PH_HUNT;
  logic [7:0] frame_addr_q;
  logic [7:0] frame_func_q;
  logic [2:0] frame_len_q;
  logic [2:0] data_count_q;
  logic [7:0] data_q [MAX_PAYLOAD_BYTES];
  logic [7:0] sum_q;

  // All inputs hold known values before the first clock edge.
  initial begin
    rx_ch.valid    = 1'b0;
    rx_ch.rx_byte  = '0;
    frame_ch.ready = 1'b0;
  end

  task automatic flag_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t ns: %s", $time, msg);
  endtask

  // Every abort path returns the whole parser to its reset contents. A byte
  // that causes an abort is consumed. It is never looked at again as a
  // possible sync byte.
  task automatic clear_parser();
    parse_state  = PH_HUNT;
    frame_addr_q = '0;
    frame_func_q = '0;
    frame_len_q  = '0;
    data_count_q = '0;
    sum_q        = '0;
    foreach (data_q[i]) data_q[i] = '0;
  endtask

  initial clear_parser();

  // Advances the model by one received byte. When a frame completes with a
  // good checksum, the frame goes onto the queue of predicted frames.
  task automatic parse_byte(input logic [7:0] b);
    frame_t     f;
    logic [2:0] n;
    case (parse_state)
      PH_HUNT: begin
        // Anything but the sync byte is line noise while hunting.
        if (b == SYNC_BYTE) begin
          parse_state = PH_ADDR;
          sum_q       = SYNC_BYTE;
        end
      end
      PH_ADDR: begin
        frame_addr_q = b;
        sum_q        = sum_q + b;
        parse_state  = PH_FUNC;
      end
      PH_FUNC: begin
        case (b)
          FUNC_LEN_SIX:  n = 3'd6;
          FUNC_LEN_TWO:  n = 3'd2;
          FUNC_LEN_FOUR: n = 3'd4;
          FUNC_LEN_ONE:  n = 3'd1;
          default:       n = 3'd0;
        endcase
        if (n == 3'd0) begin
          // An unknown function code drops the frame.
          clear_parser();
        end else begin
          frame_func_q = b;
          frame_len_q  = n;
          data_count_q = '0;
          sum_q        = sum_q + b;
          parse_state  = PH_DATA;
        end
      end
      PH_DATA: begin
        if (data_count_q < MAX_PAYLOAD_BYTES) data_q[data_count_q] = b;
        data_count_q = data_count_q + 3'd1;
        sum_q        = sum_q + b;
        if (data_count_q >= frame_len_q) parse_state = PH_SUM;
      end
      PH_SUM: begin
        if (b == sum_q) begin
          f.address   = frame_addr_q;
          f.func_code = frame_func_q;
          f.length    = frame_len_q;
          f.payload   = '0;
          for (int i = 0; i < frame_len_q; i++) f.payload[8*i +: 8] = data_q[i];
          predicted_frames.push_back(f);
        end
        // Both a good and a bad checksum return the parser to the hunt.
        clear_parser();
      end
      default: clear_parser();
    endcase
  endtask

  // Queues one complete frame. A nonzero flip value corrupts the checksum
  // byte, so that the frame must be dropped.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] code,
                            input logic [2:0] n, input logic [47:0] data,
                            input logic [7:0] flip);
    logic [7:0] sum;
    sum = SYNC_BYTE + addr + code;
    tx_bytes.push_back(SYNC_BYTE);
    tx_bytes.push_back(addr);
    tx_bytes.push_back(code);
    for (int i = 0; i < n; i++) begin
      tx_bytes.push_back(data[8*i +: 8]);
      sum = sum + data[8*i +: 8];
    end
    tx_bytes.push_back(sum ^ flip);
  endtask

  // Random traffic. Most of it is well-formed frames with random content, so
  // that the payload and checksum phases get plenty of exercise. The rest is
  // bad checksums, unknown codes, loose noise and frames cut off early.
  task automatic fill_random(input int count);
    int         target;
    int         pick;
    int         sel;
    logic [7:0] code;
    target = tx_bytes.size() + count;
    while (tx_bytes.size() < target) begin
      pick = $urandom_range(99);
      sel  = $urandom_range(3);
      if (pick < 70) begin
        send_frame(8'($urandom), FUNC_CODES[sel], FUNC_LENS[sel],
                   48'({$urandom, $urandom}), 8'h00);
      end else if (pick < 80) begin
        send_frame(8'($urandom), FUNC_CODES[sel], FUNC_LENS[sel],
                   48'({$urandom, $urandom}), 8'($urandom_range(255, 1)));
      end else if (pick < 87) begin
        code = 8'($urandom);
        while (code inside {FUNC_LEN_SIX, FUNC_LEN_TWO, FUNC_LEN_FOUR, FUNC_LEN_ONE})
          code = 8'($urandom);
        tx_bytes.push_back(SYNC_BYTE);
        tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(code);
      end else if (pick < 95) begin
        repeat ($urandom_range(4, 1)) tx_bytes.push_back(8'($urandom));
      end else begin
        // A truncated frame. The sync byte of the next frame lands inside it.
        tx_bytes.push_back(SYNC_BYTE);
        tx_bytes.push_back(8'($urandom));
        tx_bytes.push_back(FUNC_CODES[sel]);
        repeat ($urandom_range(FUNC_LENS[sel] - 1, 0))
          tx_bytes.push_back(8'($urandom));
      end
    end
  endtask

  // Byte sender. An accepted transaction is first fed to the model. After
  // that the next byte is offered, or valid drops for an idle cycle. Valid is
  // assigned once per edge, so a held valid never glitches low.
  always @(posedge clk) begin
    if (rst) begin
      rx_ch.valid   <= 1'b0;
      rx_ch.rx_byte <= '0;
    end else begin
      if (rx_ch.valid && rx_ch.ready) parse_byte(rx_ch.rx_byte);
      if (!rx_ch.valid || rx_ch.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_ch.valid   <= 1'b1;
          rx_ch.rx_byte <= tx_bytes.pop_front();
        end else begin
          rx_ch.valid <= 1'b0;
        end
      end
    end
  end

  // The frame sink stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      frame_ch.ready <= 1'b0;
    end else begin
      frame_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Frame checker. Each frame transaction is compared field by field with
  // the oldest predicted frame.
  always @(posedge clk) begin
    frame_t want;
    if (!rst && frame_ch.valid && frame_ch.ready) begin
      if (predicted_frames.size() == 0) begin
        flag_mismatch($sformatf("unexpected frame addr %h func %h len %0d data %h",
                                frame_ch.frame_address, frame_ch.frame_function,
                                frame_ch.frame_length, frame_ch.frame_payload));
      end else begin
        want = predicted_frames.pop_front();
        if (frame_ch.frame_address !== want.address)
          flag_mismatch($sformatf("frame_address %h, want %h",
                                  frame_ch.frame_address, want.address));
        if (frame_ch.frame_function !== want.func_code)
          flag_mismatch($sformatf("frame_function %h, want %h",
                                  frame_ch.frame_function, want.func_code));
        if (frame_ch.frame_length !== want.length)
          flag_mismatch($sformatf("frame_length %0d, want %0d",
                                  frame_ch.frame_length, want.length));
        if (frame_ch.frame_payload !== want.payload)
          flag_mismatch($sformatf("frame_payload %h, want %h",
                                  frame_ch.frame_payload, want.payload));
      end
    end
  end

  // Stimulus and end of test.
  initial begin
    // Directed part: extreme fields and every function code.
    repeat (3) tx_bytes.push_back(8'($urandom));
    send_frame(8'h00, FUNC_LEN_ONE,  3'd1, 48'h0,             8'h00);
    send_frame(8'hFF, FUNC_LEN_SIX,  3'd6, 48'hFFFF_FFFF_FFFF, 8'h00);
    send_frame(8'h5A, FUNC_LEN_TWO,  3'd2, 48'h0000_0000_3CA5, 8'h00);
    send_frame(8'h81, FUNC_LEN_FOUR, 3'd4, 48'h0000_7FFE_8001, 8'h00);
    // Unknown function code 0xFB. The code byte must not restart the hunt, so
    // the frame-like bytes that follow it are ignored.
    tx_bytes.push_back(SYNC_BYTE);
    tx_bytes.push_back(8'h10);
    tx_bytes.push_back(8'hFB);
    tx_bytes.push_back(8'h07);
    tx_bytes.push_back(FUNC_LEN_ONE);
    tx_bytes.push_back(8'h22);
    tx_bytes.push_back(8'h58);
    // A wrong checksum of 0xFB. That byte must not restart the hunt either.
    tx_bytes.push_back(SYNC_BYTE);
    tx_bytes.push_back(8'h01);
    tx_bytes.push_back(FUNC_LEN_ONE);
    tx_bytes.push_back(8'h00);
    tx_bytes.push_back(8'hFB);
    tx_bytes.push_back(8'h07);
    tx_bytes.push_back(FUNC_LEN_ONE);
    tx_bytes.push_back(8'h22);
    tx_bytes.push_back(8'h58);
    // The sync value in the address and payload. A plain bad checksum.
    send_frame(8'hFB, FUNC_LEN_TWO, 3'd2, 48'h0000_0000_FBFB, 8'h00);
    send_frame(8'h33, FUNC_LEN_ONE, 3'd1, 48'h0000_0000_0042, 8'h01);

    // Random traffic in three pressure mixes: a slow sink, then a slow
    // sender, then no idling at all.
    fill_random(620);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (tx_bytes.size() != 0) @(posedge clk);

    send_idle_pct = 83;
    recv_idle_pct = 22;
    fill_random(670);
    while (tx_bytes.size() != 0) @(posedge clk);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    fill_random(670);
    while (tx_bytes.size() != 0 || rx_ch.valid) @(posedge clk);
    while (predicted_frames.size() != 0) @(posedge clk);
    // A frame leaves through the input and output registers after its checksum
    // byte, so any extra frame shows up well within this window.
    repeat (10) @(posedge clk);

    if (mismatches == 0 && predicted_frames.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog. About 2000 bytes, even with heavy stalls on both sides, finish
  // far below this time.
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
